[hdl/echo_pulse_width_ranger_defines.svh]
// ----------------------------------------------------------------------------
// echo pulse width ranger assertion macros
// shared check wrappers, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef ECHO_PULSE_WIDTH_RANGER_DEFINES_SVH
`define ECHO_PULSE_WIDTH_RANGER_DEFINES_SVH

// general property, checked every cycle outside reset
`define EPWR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a result in the next
`define EPWR_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

[hdl/epwr_pkg.sv]
// ----------------------------------------------------------------------------
// epwr_pkg
// widths, reset values and codes shared by the echo ranger files
// ----------------------------------------------------------------------------
package epwr_pkg;

  localparam int CAP_W        = 16;
  localparam int WEIGHT_W     = 17;
  localparam int SCALE_W      = 16;
  localparam int DIST_W       = 25;
  localparam int CFG_DATA_W   = 17;
  localparam int CFG_IDX_W    = 1;
  localparam int OVF_BITS_DEF = 6;
  localparam int ROUND_SHIFT  = 8;

  localparam logic [WEIGHT_W-1:0]    WEIGHT_RST = 17'd65535;
  localparam logic [SCALE_W-1:0]     SCALE_RST  = 16'd1114;
  localparam logic [CAP_W-1:0]       HELD_SAT   = 16'hffff;
  localparam logic [ROUND_SHIFT-1:0] ROUND_HALF = 8'h80;
  localparam logic [DIST_W-1:0]      DIST_MAX   = 25'h1ffffff;

  typedef enum logic [1:0] {
    OP_OVERFLOW = 2'd0,
    OP_EDGE     = 2'd1,
    OP_OVF_EDGE = 2'd2,
    OP_READ     = 2'd3
  } epwr_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVERFLOW_WEIGHT = 1'b0,
    REG_DISTANCE_SCALE  = 1'b1
  } epwr_reg_t;

  typedef struct packed {
    logic evt_en;
    logic trig;
    logic load_count;
    logic load_prod;
    logic finish;
    logic out_load;
  } epwr_cmd_t;

  typedef struct packed {
    logic done;
  } epwr_stat_t;

endpackage

[hdl/epwr_if.sv]
// ----------------------------------------------------------------------------
// epwr channel interfaces
// event input, result output and register write channels
// ----------------------------------------------------------------------------
interface epwr_in_if import epwr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [CAP_W-1:0] capture_count;

  modport source (output valid, output op, output capture_count, input ready);
  modport sink (input valid, input op, input capture_count, output ready);
endinterface

interface epwr_out_if import epwr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_q8;
  logic              distance_new;
  logic              trigger_request;
  logic              measure_done;
  logic              awaiting_fall;

  modport source (output valid, output distance_q8, output distance_new,
                  output trigger_request, output measure_done, output awaiting_fall,
                  input ready);
  modport sink (input valid, input distance_q8, input distance_new,
                input trigger_request, input measure_done, input awaiting_fall,
                output ready);
endinterface

interface epwr_cfg_if import epwr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/echo_pulse_width_ranger.sv]
// Overflow, edge and unfinished-read words give their result word in the cycle after accept.
// A read of a finished measurement steps through the count, scale and round states first.
// Events are taken one word per cycle while the result register is free or being taken;
// a finished read blocks new words until count multiply-add, scale multiply and rounding finish.
// Reset (rst, synchronous): clears flags, overflow count, held and last distance,
// loads register defaults and empties the result register.
// ----------------------------------------------------------------------------
// echo_pulse_width_ranger
// echo pulse width capture and distance scaling, top level
// ----------------------------------------------------------------------------
module echo_pulse_width_ranger import epwr_pkg::*; #(
  parameter int OVERFLOW_BITS = OVF_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  epwr_in_if.sink     item_in,
  epwr_out_if.source  result_out,
  epwr_cfg_if.sink    cfg
);

  epwr_cmd_t  cmd;
  epwr_stat_t stat;

  assign cfg.ready = 1'b1;

  epwr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .op        (item_in.op),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  epwr_dpath #(
    .OVERFLOW_BITS (OVERFLOW_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .op              (item_in.op),
    .capture_count   (item_in.capture_count),
    .cfg_we          (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .distance_q8     (result_out.distance_q8),
    .distance_new    (result_out.distance_new),
    .trigger_request (result_out.trigger_request),
    .measure_done    (result_out.measure_done),
    .awaiting_fall   (result_out.awaiting_fall)
  );

endmodule

[hdl/epwr_ctrl.sv]
// ----------------------------------------------------------------------------
// epwr_ctrl
// sequencer: takes words, steps the distance computation, owns output valid
// ----------------------------------------------------------------------------
`include "echo_pulse_width_ranger_defines.svh"

module epwr_ctrl import epwr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  output logic       out_valid,
  input  logic       out_ready,
  input  epwr_stat_t stat,
  output epwr_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_COUNT = 4'b0010,
    S_SCALE = 4'b0100,
    S_ROUND = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_acc;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (op == OP_READ) begin
            if (stat.done) begin
              state_next = S_COUNT;
            end else begin
              cmd.trig     = 1'b1;
              cmd.out_load = 1'b1;
            end
          end else begin
            // events after done leave the state alone
            cmd.evt_en   = !stat.done;
            cmd.out_load = 1'b1;
          end
        end
      end
      S_COUNT: begin
        cmd.load_count = 1'b1;
        state_next     = S_SCALE;
      end
      S_SCALE: begin
        cmd.load_prod = 1'b1;
        state_next    = S_ROUND;
      end
      S_ROUND: begin
        cmd.finish   = 1'b1;
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `EPWR_ASSERT_NEXT(a_read_starts, in_acc && (op == OP_READ) && stat.done, state == S_COUNT, "read of finished measurement did not start computation")
  `EPWR_ASSERT_NEXT(a_round_delivers, state == S_ROUND, out_valid, "distance result not presented")
  `EPWR_ASSERT(a_busy_blocks, (state != S_IDLE) |-> !in_ready, "word accepted during computation")

endmodule

[hdl/epwr_dpath.sv]
// ----------------------------------------------------------------------------
// epwr_dpath
// measurement state, registers, count and scale multipliers, result register
// ----------------------------------------------------------------------------
`include "echo_pulse_width_ranger_defines.svh"

module epwr_dpath import epwr_pkg::*; #(
  parameter int OVERFLOW_BITS = OVF_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  epwr_cmd_t             cmd,
  output epwr_stat_t            stat,
  input  logic [1:0]            op,
  input  logic [CAP_W-1:0]      capture_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [DIST_W-1:0]     distance_q8,
  output logic                  distance_new,
  output logic                  trigger_request,
  output logic                  measure_done,
  output logic                  awaiting_fall
);

  localparam int WprodW = WEIGHT_W + OVERFLOW_BITS;
  localparam int CountW = WprodW + 1;
  localparam int ProdW  = CountW + SCALE_W;
  localparam int RoundW = ProdW + 1;
  localparam logic [OVERFLOW_BITS-1:0] OvfTop = {OVERFLOW_BITS{1'b1}};

  logic [WEIGHT_W-1:0]      overflow_weight;
  logic [SCALE_W-1:0]       distance_scale;
  logic                     done_flag;
  logic                     armed_flag;
  logic [OVERFLOW_BITS-1:0] ovf_count;
  logic [CAP_W-1:0]         held_count;
  logic [DIST_W-1:0]        last_distance;
  logic [CountW-1:0]        count;
  logic [ProdW-1:0]         prod;

  logic                     done_next;
  logic                     armed_next;
  logic [OVERFLOW_BITS-1:0] ovf_count_next;
  logic [CAP_W-1:0]         held_count_next;
  logic [WprodW-1:0]        wprod;
  logic [CountW-1:0]        count_next;
  logic [ProdW-1:0]         prod_next;
  logic [RoundW-1:0]        rounded;
  logic [DIST_W-1:0]        dist_sat;

  assign stat.done = done_flag;

  always_comb begin
    done_next       = done_flag;
    armed_next      = armed_flag;
    ovf_count_next  = ovf_count;
    held_count_next = held_count;
    if (cmd.evt_en) begin
      if (((op == OP_OVERFLOW) || (op == OP_OVF_EDGE)) && armed_flag) begin
        if (ovf_count == OvfTop) begin
          done_next       = 1'b1;
          held_count_next = HELD_SAT;
        end else begin
          ovf_count_next = ovf_count + OVERFLOW_BITS'(1);
        end
      end
      // edge after overflow in the same word overwrites the held count
      if ((op == OP_EDGE) || (op == OP_OVF_EDGE)) begin
        if (armed_flag) begin
          done_next       = 1'b1;
          held_count_next = capture_count;
        end else begin
          armed_next      = 1'b1;
          ovf_count_next  = '0;
          held_count_next = '0;
        end
      end
    end
    if (cmd.finish) begin
      done_next      = 1'b0;
      armed_next     = 1'b0;
      ovf_count_next = '0;
    end
  end

  assign wprod      = WprodW'(overflow_weight) * WprodW'(ovf_count);
  assign count_next = CountW'(held_count) + CountW'(wprod);
  assign prod_next  = ProdW'(count) * ProdW'(distance_scale);
  assign rounded    = RoundW'(prod) + RoundW'(ROUND_HALF);

  // round to q8 and clamp to the result width
  always_comb begin
    if (|rounded[RoundW-1:ROUND_SHIFT+DIST_W]) begin
      dist_sat = DIST_MAX;
    end else begin
      dist_sat = rounded[ROUND_SHIFT+DIST_W-1:ROUND_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_weight <= WEIGHT_RST;
      distance_scale  <= SCALE_RST;
      done_flag       <= 1'b0;
      armed_flag      <= 1'b0;
      ovf_count       <= '0;
      held_count      <= '0;
      last_distance   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OVERFLOW_WEIGHT: overflow_weight <= cfg_data[WEIGHT_W-1:0];
          REG_DISTANCE_SCALE:  distance_scale  <= cfg_data[SCALE_W-1:0];
          default: begin
          end
        endcase
      end
      done_flag  <= done_next;
      armed_flag <= armed_next;
      ovf_count  <= ovf_count_next;
      held_count <= held_count_next;
      if (cmd.finish) begin
        last_distance <= dist_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_count) begin
      count <= count_next;
    end
    if (cmd.load_prod) begin
      prod <= prod_next;
    end
    if (cmd.out_load) begin
      distance_q8     <= cmd.finish ? dist_sat : last_distance;
      distance_new    <= cmd.finish;
      trigger_request <= cmd.trig;
      measure_done    <= done_next;
      awaiting_fall   <= armed_next && !done_next;
    end
  end

  `EPWR_ASSERT_NEXT(a_finish_clears, cmd.finish, !done_flag && !armed_flag && (ovf_count == '0), "read did not clear measurement status")
  `EPWR_ASSERT(a_evt_live, cmd.evt_en |-> !done_flag, "event applied to finished measurement")
  `EPWR_ASSERT(a_prod_order, cmd.load_prod |-> $past(cmd.load_count), "scale step without count step")

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// drives overflow, edge and read words into the echo ranger, predicts each
// result word from a local copy of the measurement state and compares it
// field by field, under random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb_top;
  import epwr_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] distance_q8;
    logic              distance_new;
    logic              trigger_request;
    logic              measure_done;
    logic              awaiting_fall;
  } ranger_word_t;

  logic clk = 1'b0;
  logic rst;

  epwr_in_if  item_if ();
  epwr_out_if result_if ();
  epwr_cfg_if cfg_if ();

  echo_pulse_width_ranger dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_if),
    .result_out (result_if),
    .cfg        (cfg_if)
  );

  always #5 clk = ~clk;

  // local copy of the measurement state and registers
  logic                    meas_done;
  logic                    meas_armed;
  logic [OVF_BITS_DEF-1:0] ovf_count;
  logic [CAP_W-1:0]        held_count;
  logic [DIST_W-1:0]       last_distance;
  logic [WEIGHT_W-1:0]     weight_reg;
  logic [SCALE_W-1:0]      scale_reg;

  ranger_word_t pending_words[$];
  int error_count = 0;
  int sent_count = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  logic [15:0] stall_pattern = '1;
  int stall_slot = 0;

  function automatic ranger_word_t next_ranger_word(epwr_op_t op, logic [CAP_W-1:0] cap);
    logic [63:0] total;
    logic [63:0] scaled;
    ranger_word_t w;
    w.distance_new = 1'b0;
    w.trigger_request = 1'b0;
    if (op == OP_READ) begin
      if (meas_done) begin
        total = 64'(held_count) + 64'(weight_reg) * 64'(ovf_count);
        scaled = (total * 64'(scale_reg) + 64'(ROUND_HALF)) >> ROUND_SHIFT;
        last_distance = (scaled > 64'(DIST_MAX)) ? DIST_MAX : scaled[DIST_W-1:0];
        meas_done = 1'b0;
        meas_armed = 1'b0;
        ovf_count = '0;
        w.distance_new = 1'b1;
      end else begin
        w.trigger_request = 1'b1;
      end
    end else if (!meas_done) begin
      // done is sampled once; the edge half of an overflow-edge word still runs
      if ((op == OP_OVERFLOW || op == OP_OVF_EDGE) && meas_armed) begin
        if (ovf_count == '1) begin
          meas_done = 1'b1;
          held_count = HELD_SAT;
        end else begin
          ovf_count = ovf_count + 1'b1;
        end
      end
      if (op == OP_EDGE || op == OP_OVF_EDGE) begin
        if (meas_armed) begin
          meas_done = 1'b1;
          held_count = cap;
        end else begin
          ovf_count = '0;
          held_count = '0;
          meas_armed = 1'b1;
        end
      end
    end
    w.distance_q8 = last_distance;
    w.measure_done = meas_done;
    w.awaiting_fall = meas_armed && !meas_done;
    return w;
  endfunction

  function automatic logic [CAP_W-1:0] random_cap();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return CAP_W'($urandom);
    endcase
  endfunction

  task automatic send_word(epwr_op_t op, logic [CAP_W-1:0] cap);
    if (gaps_on && burst_left == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    item_if.valid <= 1'b1;
    item_if.op <= op;
    item_if.capture_count <= cap;
    do @(posedge clk); while (!item_if.ready);
    pending_words.push_back(next_ranger_word(op, cap));
    sent_count++;
  endtask

  // block is idle once every result is back and a read has had time to finish
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_registers(logic [CFG_DATA_W-1:0] weight, logic [CFG_DATA_W-1:0] scale);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_OVERFLOW_WEIGHT;
    cfg_if.data <= weight;
    do @(posedge clk); while (!cfg_if.ready);
    weight_reg = weight;
    cfg_if.index <= REG_DISTANCE_SCALE;
    cfg_if.data <= scale;
    do @(posedge clk); while (!cfg_if.ready);
    scale_reg = scale[SCALE_W-1:0];
    cfg_if.valid <= 1'b0;
  endtask

  // maybe stray events, arm, count overflows, finish, maybe stray events, read; finish or read may be skipped
  task automatic run_measurement();
    int n_ovf;
    bit drop_finish;
    bit drop_read;
    drop_finish = 1'b0;
    drop_read = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) send_word(epwr_op_t'($urandom_range(0, 3)), random_cap());
    end
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) drop_finish = 1'b1;
      else drop_read = 1'b1;
    end
    n_ovf = ($urandom_range(0, 3) == 0) ? $urandom_range(61, 66) : $urandom_range(0, 8);
    send_word($urandom_range(0, 1) ? OP_EDGE : OP_OVF_EDGE, random_cap());
    for (int i = 0; i < n_ovf; i++) begin
      send_word(($urandom_range(0, 15) == 0) ? OP_READ : OP_OVERFLOW, random_cap());
    end
    if (!drop_finish) send_word($urandom_range(0, 1) ? OP_EDGE : OP_OVF_EDGE, random_cap());
    repeat ($urandom_range(0, 2)) send_word(epwr_op_t'($urandom_range(0, 2)), random_cap());
    if (!drop_read) send_word(OP_READ, random_cap());
  endtask

  task automatic test_unarmed_and_done();
    send_word(OP_OVERFLOW, '1);
    send_word(OP_READ, '0);
    send_word(OP_OVF_EDGE, 16'h1234);
    send_word(OP_READ, '1);
    send_word(OP_EDGE, '1);
    send_word(OP_OVERFLOW, '0);
    send_word(OP_EDGE, 16'h00ff);
    send_word(OP_OVF_EDGE, 16'hff00);
    send_word(OP_READ, '0);
    send_word(OP_READ, '0);
  endtask

  task automatic test_overflow_then_edge();
    send_word(OP_EDGE, 16'haaaa);
    send_word(OP_OVERFLOW, '0);
    send_word(OP_OVERFLOW, '0);
    send_word(OP_OVF_EDGE, '0);
    send_word(OP_READ, 16'h5555);
  endtask

  task automatic test_register_extremes();
    set_registers('0, 17'(16'hffff));
    send_word(OP_EDGE, '0);
    repeat (3) send_word(OP_OVERFLOW, '0);
    send_word(OP_EDGE, '1);
    send_word(OP_READ, '0);
    set_registers('1, '0);
    send_word(OP_EDGE, '0);
    send_word(OP_OVERFLOW, '0);
    send_word(OP_EDGE, 16'h5555);
    send_word(OP_READ, '0);
  endtask

  task automatic test_random_measurements();
    int start;
    start = sent_count;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_registers(17'(WEIGHT_RST), 17'(SCALE_RST));
        1: set_registers(17'd1, 17'h0ffff);
        2: set_registers(17'd65536, 17'd1);
        default: set_registers(17'($urandom_range(0, 131071)), 17'($urandom));
      endcase
      gaps_on = (phase != 3);
      while (sent_count < start + (phase + 1) * 1150 / 6) run_measurement();
    end
    gaps_on = 1'b1;
  endtask

  function automatic void check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    ranger_word_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        error_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("distance_q8", want.distance_q8, result_if.distance_q8);
        check_field("distance_new", want.distance_new, result_if.distance_new);
        check_field("trigger_request", want.trigger_request, result_if.trigger_request);
        check_field("measure_done", want.measure_done, result_if.measure_done);
        check_field("awaiting_fall", want.awaiting_fall, result_if.awaiting_fall);
      end
    end
  end

  // receiver stall pattern, reloaded each time the slot counter wraps to zero
  always @(posedge clk) begin
    if (stall_slot == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pattern = '1;
        1, 2: stall_pattern = 16'($urandom);
        default: stall_pattern = 16'($urandom) & 16'($urandom);
      endcase
    end
    result_if.ready <= stall_pattern[stall_slot];
    stall_slot = (stall_slot + 1) % 16;
  end

  initial begin
    int drain;
    rst <= 1'b1;
    item_if.valid <= 1'b0;
    item_if.op <= OP_OVERFLOW;
    item_if.capture_count <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_OVERFLOW_WEIGHT;
    cfg_if.data <= '0;
    meas_done = 1'b0;
    meas_armed = 1'b0;
    ovf_count = '0;
    held_count = '0;
    last_distance = '0;
    weight_reg = WEIGHT_RST;
    scale_reg = SCALE_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_unarmed_and_done();
    test_overflow_then_edge();
    test_register_extremes();
    test_random_measurements();

    item_if.valid <= 1'b0;
    drain = 0;
    while (pending_words.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    if (pending_words.size() != 0) begin
      $error("%0d result words never arrived", pending_words.size());
      error_count++;
    end
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("echo_pulse_width_ranger test passed");
    end else begin
      $display("echo_pulse_width_ranger test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("echo_pulse_width_ranger test failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/epwr_pkg.sv
hdl/epwr_if.sv
hdl/epwr_ctrl.sv
hdl/epwr_dpath.sv
hdl/echo_pulse_width_ranger.sv
verif/tb_top.sv
